// ===== hw/rtl/tlbfl_pkg.sv =====
// ============================================================================
// tlbfl_pkg
// shared types and constants for the fifo/lru translation buffer
// ============================================================================
`default_nettype none

package tlbfl_pkg;

    localparam int TLB_DEPTH = 16;
    localparam int IDX_W = $clog2(TLB_DEPTH);
    localparam int CNT_W = $clog2(TLB_DEPTH + 1);

    localparam logic [1:0] POLICY_FIFO   = 2'd0;
    localparam logic [1:0] POLICY_LRU    = 2'd1;
    localparam logic [1:0] POLICY_FIXED  = 2'd2;
    localparam logic [1:0] POLICY_UNUSED = 2'd3;

    localparam logic [1:0] ST_HIT    = 2'd0;
    localparam logic [1:0] ST_MISS   = 2'd1;
    localparam logic [1:0] ST_FILLED = 2'd2;

    localparam logic [1:0] REG_POLICY = 2'd0;
    localparam logic [1:0] REG_LIMIT  = 2'd1;
    localparam logic [1:0] REG_PSIZE  = 2'd2;

    localparam logic [16:0] PSIZE_RESET = 17'd64;
    localparam logic [4:0]  LIMIT_RESET = 5'd16;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_SCAN,
        S_STORE,
        S_MUL,
        S_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic div_step;
        logic scan_step;
        logic store;
        logic hit_update;
        logic mul;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic scan_done;
        logic kind;
        logic hit;
        logic store_en;
    } sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tlbfl_datapath.sv =====
// ============================================================================
// tlbfl_datapath
// divider, entry store, serial search and address multiply
// ============================================================================
`default_nettype none

module tlbfl_datapath (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire tlbfl_pkg::cmd_t    cmd,
    output tlbfl_pkg::sts_t         sts,
    input  wire logic [1:0]         replace_policy,
    input  wire logic [4:0]         entry_limit,
    input  wire logic [16:0]        page_size,
    input  wire logic               kind,
    input  wire logic [15:0]        pid,
    input  wire logic [31:0]        logical_address,
    input  wire logic [15:0]        frame,
    output logic [1:0]              status,
    output logic [31:0]             page,
    output logic [31:0]             physical_address
);

    localparam int IW = tlbfl_pkg::IDX_W;
    localparam int CW = tlbfl_pkg::CNT_W;

    logic [15:0] epid [tlbfl_pkg::TLB_DEPTH];
    logic [31:0] epage [tlbfl_pkg::TLB_DEPTH];
    logic [15:0] eframe [tlbfl_pkg::TLB_DEPTH];
    logic [31:0] ebirth [tlbfl_pkg::TLB_DEPTH];
    logic [31:0] euse [tlbfl_pkg::TLB_DEPTH];

    logic        kind_reg;
    logic [15:0] pid_reg;
    logic [15:0] frame_reg;
    logic [16:0] ps_reg;
    logic [31:0] quo_reg;
    logic [16:0] rem_reg;
    logic [5:0]  dcnt_reg;
    logic [CW-1:0] filled_reg;
    logic [31:0] time_reg;
    logic [CW-1:0] sidx_reg;
    logic        hit_reg;
    logic [IW-1:0] hidx_reg;
    logic [IW-1:0] best_reg;
    logic [31:0] best_t_reg;
    logic [15:0] mframe_reg;
    logic [31:0] prod;
    logic [CW-1:0] limit;
    logic [17:0] trial;
    logic [IW-1:0] sidx;
    logic [31:0] ent_t;
    logic [IW-1:0] slot;
    logic          fill_free;

    assign limit = (entry_limit > 5'(tlbfl_pkg::TLB_DEPTH))
        ? CW'(tlbfl_pkg::TLB_DEPTH) : CW'(entry_limit);
    assign fill_free = filled_reg < limit;
    assign trial = {rem_reg, quo_reg[31]} - {1'b0, ps_reg};
    assign sidx = sidx_reg[IW-1:0];
    assign ent_t = (replace_policy == tlbfl_pkg::POLICY_FIFO) ? ebirth[sidx] : euse[sidx];
    assign slot = fill_free ? filled_reg[IW-1:0]
        : ((replace_policy == tlbfl_pkg::POLICY_FIFO
           || replace_policy == tlbfl_pkg::POLICY_LRU) ? best_reg : '0);

    assign sts.div_done  = (dcnt_reg == 6'd0);
    assign sts.scan_done = (sidx_reg >= filled_reg) || hit_reg
        || (kind_reg && fill_free);
    assign sts.kind      = kind_reg;
    assign sts.hit       = hit_reg;
    assign sts.store_en  = (limit != '0);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg  <= kind;
            pid_reg   <= pid;
            frame_reg <= frame;
            ps_reg    <= (page_size == 17'd0) ? 17'd1 : page_size;
            quo_reg   <= logical_address;
            rem_reg   <= '0;
        end
        else if (cmd.div_step)
        begin
            if (!trial[17])
            begin
                rem_reg <= trial[16:0];
                quo_reg <= {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_reg <= {rem_reg[15:0], quo_reg[31]};
                quo_reg <= {quo_reg[30:0], 1'b0};
            end
        end
        if (cmd.scan_step)
        begin
            if (!kind_reg)
            begin
                if (epid[sidx] == pid_reg && epage[sidx] == quo_reg)
                begin
                    hidx_reg <= sidx;
                end
            end
            else if (sidx_reg == '0 || ent_t < best_t_reg)
            begin
                best_reg   <= sidx;
                best_t_reg <= ent_t;
            end
        end
        if (cmd.store)
        begin
            epid[slot]   <= pid_reg;
            epage[slot]  <= quo_reg;
            eframe[slot] <= frame_reg;
            ebirth[slot] <= time_reg;
            euse[slot]   <= time_reg;
        end
        if (cmd.hit_update)
        begin
            euse[hidx_reg] <= time_reg;
        end
        if (cmd.mul)
        begin
            mframe_reg <= kind_reg ? frame_reg : eframe[hidx_reg];
        end
        if (cmd.out_load)
        begin
            page             <= quo_reg;
            status           <= kind_reg ? tlbfl_pkg::ST_FILLED
                : (hit_reg ? tlbfl_pkg::ST_HIT : tlbfl_pkg::ST_MISS);
            physical_address <= (kind_reg || hit_reg)
                ? prod + {15'd0, rem_reg} : 32'd0;
        end
    end

    assign prod = 32'({15'd0, ps_reg} * {16'd0, mframe_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dcnt_reg   <= '0;
            filled_reg <= '0;
            time_reg   <= '0;
            sidx_reg   <= '0;
            hit_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                dcnt_reg <= 6'd32;
                sidx_reg <= '0;
                hit_reg  <= 1'b0;
            end
            else
            begin
                if (cmd.div_step)
                begin
                    dcnt_reg <= dcnt_reg - 6'd1;
                end
                if (cmd.scan_step)
                begin
                    sidx_reg <= sidx_reg + CW'(1);
                    if (!kind_reg && epid[sidx] == pid_reg && epage[sidx] == quo_reg)
                    begin
                        hit_reg <= 1'b1;
                    end
                end
            end
            if (cmd.store)
            begin
                time_reg <= time_reg + 32'd1;
                if (fill_free)
                begin
                    filled_reg <= filled_reg + CW'(1);
                end
            end
            if (cmd.hit_update)
            begin
                time_reg <= time_reg + 32'd1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && cmd.store)
        begin
            assert (limit != '0) else $error("store with zero limit");
        end
    end

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        filled_reg <= CW'(tlbfl_pkg::TLB_DEPTH))
        else $error("fill count beyond depth");
    a_time_step: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.store |=> time_reg == $past(time_reg) + 32'd1)
        else $error("time counter did not advance");
    a_no_double: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.store && cmd.hit_update))
        else $error("store and hit update together");

endmodule

`default_nettype wire

// ===== hw/rtl/tlbfl_ctrl.sv =====
// ============================================================================
// tlbfl_ctrl
// sequencer for divide, search, store and result
// ============================================================================
`default_nettype none

module tlbfl_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            req_valid,
    output logic                 req_stall,
    output logic                 rsp_valid,
    input  wire logic            rsp_stall,
    input  wire logic [1:0]      replace_policy,
    output tlbfl_pkg::cmd_t      cmd,
    input  wire tlbfl_pkg::sts_t sts
);

    tlbfl_pkg::state_t state_reg, state_next;
    logic              rsp_valid_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tlbfl_pkg::S_IDLE:  if (req_valid) state_next = tlbfl_pkg::S_DIV;
            tlbfl_pkg::S_DIV:   if (sts.div_done) state_next = tlbfl_pkg::S_SCAN;
            tlbfl_pkg::S_SCAN:
                if (sts.scan_done)
                    state_next = (sts.kind && sts.store_en) ? tlbfl_pkg::S_STORE
                        : tlbfl_pkg::S_MUL;
            tlbfl_pkg::S_STORE: state_next = tlbfl_pkg::S_MUL;
            tlbfl_pkg::S_MUL:   state_next = tlbfl_pkg::S_OUT;
            tlbfl_pkg::S_OUT:
                if (!rsp_valid || !rsp_stall) state_next = tlbfl_pkg::S_IDLE;
            default:            state_next = tlbfl_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        req_stall = 1'b1;
        rsp_valid_next = rsp_valid && rsp_stall;
        case (state_reg)
            tlbfl_pkg::S_IDLE:
            begin
                req_stall = 1'b0;
                cmd.load  = req_valid;
            end
            tlbfl_pkg::S_DIV:   cmd.div_step = !sts.div_done;
            tlbfl_pkg::S_SCAN:
            begin
                cmd.scan_step  = !sts.scan_done;
                cmd.hit_update = sts.scan_done && !sts.kind && sts.hit
                    && replace_policy == tlbfl_pkg::POLICY_LRU;
            end
            tlbfl_pkg::S_STORE: cmd.store = 1'b1;
            tlbfl_pkg::S_MUL:   cmd.mul = 1'b1;
            tlbfl_pkg::S_OUT:
            begin
                if (!rsp_valid || !rsp_stall)
                begin
                    cmd.out_load   = 1'b1;
                    rsp_valid_next = 1'b1;
                end
            end
            default:            cmd = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tlbfl_pkg::S_IDLE;
            rsp_valid <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rsp_valid <= rsp_valid_next;
        end
    end

    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> state_reg == tlbfl_pkg::S_IDLE)
        else $error("load outside idle");
    a_out_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> rsp_valid)
        else $error("result not presented");
    a_store_fill: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.store |-> sts.kind)
        else $error("store on translate");

endmodule

`default_nettype wire

// ===== hw/rtl/tlb_translate_fifo_lru_unit.sv =====
// ============================================================================
// tlb_translate_fifo_lru_unit
// fully associative tlb with fifo, lru or fixed-slot replacement
// ============================================================================
// One request at a time. After a request is taken, the restoring division by
// page_size runs bit-serially, then the search examines one entry per cycle
// (the victim scan on a full fill likewise; a fill with a free slot needs no
// scan), a fill with a nonzero limit adds a store state, then come the
// multiply and result states, plus stalls at the result. The result register
// frees the core, so the next request is taken in the idle cycle after the
// result has been loaded.
`default_nettype none

module tlb_translate_fifo_lru_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [16:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        kind,
    input  wire logic [15:0] pid,
    input  wire logic [31:0] logical_address,
    input  wire logic [15:0] frame,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       status,
    output logic [31:0]      page,
    output logic [31:0]      physical_address
);

    logic [1:0]  policy_reg;
    logic [4:0]  limit_reg;
    logic [16:0] psize_reg;
    tlbfl_pkg::cmd_t cmd;
    tlbfl_pkg::sts_t sts;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg <= tlbfl_pkg::POLICY_FIFO;
            limit_reg  <= tlbfl_pkg::LIMIT_RESET;
            psize_reg  <= tlbfl_pkg::PSIZE_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                tlbfl_pkg::REG_POLICY: policy_reg <= cfg_data[1:0];
                tlbfl_pkg::REG_LIMIT:  limit_reg  <= cfg_data[4:0];
                tlbfl_pkg::REG_PSIZE:  psize_reg  <= cfg_data;
                default:               policy_reg <= policy_reg;
            endcase
        end
    end

    tlbfl_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (in_valid),
        .req_stall      (in_stall),
        .rsp_valid      (out_valid),
        .rsp_stall      (out_stall),
        .replace_policy (policy_reg),
        .cmd            (cmd),
        .sts            (sts)
    );

    tlbfl_datapath u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .sts              (sts),
        .replace_policy   (policy_reg),
        .entry_limit      (limit_reg),
        .page_size        (psize_reg),
        .kind             (kind),
        .pid              (pid),
        .logical_address  (logical_address),
        .frame            (frame),
        .status           (status),
        .page             (page),
        .physical_address (physical_address)
    );

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
// ============================================================================
// testbench
// self-checking bench for the translation buffer: directed table, then random
// translate/fill traffic in phases of policy, limit and page size, checked
// against an in-bench model of the entry store and replacement
// ============================================================================
`default_nettype none

module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 2000000;

    typedef struct packed {
        logic        kind;
        logic [15:0] pid;
        logic [31:0] addr;
        logic [15:0] frame;
    } request_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] page;
        logic [31:0] phys;
    } xlat_t;

    typedef struct {
        request_t req;
        logic     known;
        xlat_t    res;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [16:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic        kind;
    logic [15:0] pid;
    logic [31:0] logical_address;
    logic [15:0] frame;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  status;
    logic [31:0] page;
    logic [31:0] physical_address;

    tlb_translate_fifo_lru_unit u_top (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .kind(kind), .pid(pid), .logical_address(logical_address), .frame(frame),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .page(page), .physical_address(physical_address)
    );

    // model state
    logic [1:0]  m_policy;
    logic [4:0]  m_limit;
    logic [16:0] m_psize;
    logic [15:0] m_pid [tlbfl_pkg::TLB_DEPTH];
    logic [31:0] m_page [tlbfl_pkg::TLB_DEPTH];
    logic [15:0] m_frame [tlbfl_pkg::TLB_DEPTH];
    logic [31:0] m_birth [tlbfl_pkg::TLB_DEPTH];
    logic [31:0] m_use [tlbfl_pkg::TLB_DEPTH];
    int          m_count;
    logic [31:0] m_clock;

    xlat_t   pending_xlat [$];
    int      errors;
    int      cycles;
    int      in_idle_pct;
    int      out_idle_pct;
    logic [15:0] pid_pool [4];

    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic xlat_t translate_step(request_t r);
        xlat_t       o;
        logic [31:0] ps;
        logic [31:0] off;
        int          lim;
        int          slot;
        int          i;
        ps = (m_psize == 0) ? 32'd1 : 32'(m_psize);
        o.page = r.addr / ps;
        off = r.addr % ps;
        o.status = tlbfl_pkg::ST_MISS;
        o.phys = '0;
        lim = (m_limit > tlbfl_pkg::TLB_DEPTH) ? tlbfl_pkg::TLB_DEPTH : int'(m_limit);
        if (r.kind == 1'b0)
        begin
            for (i = 0; i < m_count; i++)
            begin
                if (m_pid[i] == r.pid && m_page[i] == o.page)
                begin
                    if (m_policy == tlbfl_pkg::POLICY_LRU)
                    begin
                        m_use[i] = m_clock;
                        m_clock++;
                    end
                    o.status = tlbfl_pkg::ST_HIT;
                    o.phys = ps * 32'(m_frame[i]) + off;
                    break;
                end
            end
        end
        else
        begin
            if (lim != 0)
            begin
                if (m_count < lim)
                begin
                    slot = m_count;
                    m_count++;
                end
                else
                begin
                    slot = 0;
                    for (i = 1; i < m_count; i++)
                    begin
                        if (m_policy == tlbfl_pkg::POLICY_FIFO && m_birth[i] < m_birth[slot])
                            slot = i;
                        else if (m_policy == tlbfl_pkg::POLICY_LRU && m_use[i] < m_use[slot])
                            slot = i;
                    end
                end
                m_pid[slot] = r.pid;
                m_page[slot] = o.page;
                m_frame[slot] = r.frame;
                m_birth[slot] = m_clock;
                m_use[slot] = m_clock;
                m_clock++;
            end
            o.status = tlbfl_pkg::ST_FILLED;
            o.phys = ps * 32'(r.frame) + off;
        end
        return o;
    endfunction

    task automatic write_reg(input logic [1:0] idx, input logic [16:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            tlbfl_pkg::REG_POLICY: m_policy = val[1:0];
            tlbfl_pkg::REG_LIMIT:  m_limit = val[4:0];
            default:               m_psize = val;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain;
        wait (pending_xlat.size() == 0);
        repeat (60) @(posedge clk);
    endtask

    task automatic send(input request_t r);
        @(negedge clk);
        while ($urandom_range(99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        kind <= r.kind;
        pid <= r.pid;
        logical_address <= r.addr;
        frame <= r.frame;
        do @(posedge clk); while (in_stall);
        pending_xlat.push_back(translate_step(r));
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    function automatic request_t random_request();
        request_t r;
        r.kind = ($urandom_range(99) < 40);
        r.pid = ($urandom_range(9) == 0) ? 16'($urandom) : pid_pool[$urandom_range(3)];
        if ($urandom_range(4) == 0)
            r.addr = $urandom;
        else
            r.addr = 32'(m_psize) * $urandom_range(24) + $urandom_range(65535);
        r.frame = 16'($urandom);
        return r;
    endfunction

    // output side
    always @(negedge clk)
        out_stall <= ($urandom_range(99) < out_idle_pct);

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tlb_translate_fifo_lru_unit: mismatch");
            $finish;
        end
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_xlat.size() == 0)
            begin
                $display("%0t unexpected result status=%0d page=%h phys=%h",
                         $time, status, page, physical_address);
                errors++;
            end
            else
            begin
                xlat_t e;
                e = pending_xlat.pop_front();
                if (e.status !== status)
                begin
                    $display("%0t status expected %0d actual %0d", $time, e.status, status);
                    errors++;
                end
                if (e.page !== page)
                begin
                    $display("%0t page expected %h actual %h", $time, e.page, page);
                    errors++;
                end
                if (e.phys !== physical_address)
                begin
                    $display("%0t phys expected %h actual %h", $time, e.phys,
                             physical_address);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        row_t  rows [$];
        row_t  row;
        xlat_t got;
        int    ph;
        int    n;
        logic [4:0]  limits [6];
        logic [16:0] sizes [6];
        logic [1:0]  pols [6];

        limits = '{5'd16, 5'd1, 5'd0, 5'd4, 5'd31, 5'd2};
        sizes = '{17'd64, 17'd1, 17'd65536, 17'd0, 17'd4096, 17'd100};
        pols = '{tlbfl_pkg::POLICY_FIFO, tlbfl_pkg::POLICY_LRU, tlbfl_pkg::POLICY_FIXED,
                 tlbfl_pkg::POLICY_UNUSED, tlbfl_pkg::POLICY_LRU, tlbfl_pkg::POLICY_FIFO};
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        kind = 1'b0;
        pid = '0;
        logical_address = '0;
        frame = '0;
        in_idle_pct = 0;
        out_idle_pct = 0;
        m_policy = tlbfl_pkg::POLICY_FIFO;
        m_limit = tlbfl_pkg::LIMIT_RESET;
        m_psize = tlbfl_pkg::PSIZE_RESET;
        m_count = 0;
        m_clock = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed table
        rows.push_back('{'{1'b0, 16'h0000, 32'h0000_0000, 16'h0}, 1'b1,
                         '{tlbfl_pkg::ST_MISS, 32'h0, 32'h0}});
        rows.push_back('{'{1'b0, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF}, 1'b1,
                         '{tlbfl_pkg::ST_MISS, 32'h03FF_FFFF, 32'h0}});
        rows.push_back('{'{1'b1, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF}, 1'b1,
                         '{tlbfl_pkg::ST_FILLED, 32'h03FF_FFFF, 32'h003F_FFFF}});
        rows.push_back('{'{1'b0, 16'hFFFF, 32'hFFFF_FFC0, 16'h0}, 1'b1,
                         '{tlbfl_pkg::ST_HIT, 32'h03FF_FFFF, 32'h003F_FFC0}});
        rows.push_back('{'{1'b1, 16'h0000, 32'h0000_0000, 16'h0000}, 1'b1,
                         '{tlbfl_pkg::ST_FILLED, 32'h0, 32'h0}});
        rows.push_back('{'{1'b1, 16'h0000, 32'h0000_0010, 16'h0005}, 1'b0, '0});
        rows.push_back('{'{1'b0, 16'h0000, 32'h0000_0020, 16'h0}, 1'b0, '0});
        rows.push_back('{'{1'b0, 16'h0001, 32'h0000_0020, 16'h0}, 1'b0, '0});
        for (int i = 0; i < 14; i++)
            rows.push_back('{'{1'b1, 16'h00A5, 32'(i) * 64 + 3, 16'(i + 7)}, 1'b0, '0});
        rows.push_back('{'{1'b1, 16'h5A5A, 32'h1234_5678, 16'hABCD}, 1'b0, '0});
        rows.push_back('{'{1'b0, 16'h00A5, 32'h0000_0043, 16'h0}, 1'b0, '0});
        rows.push_back('{'{1'b0, 16'h5A5A, 32'h1234_5678, 16'h0}, 1'b0, '0});
        foreach (rows[i])
        begin
            row = rows[i];
            send(row.req);
            if (row.known)
            begin
                got = pending_xlat[pending_xlat.size() - 1];
                if (got !== row.res)
                begin
                    $display("%0t table row %0d expected %h actual %h", $time, i,
                             row.res, got);
                    errors++;
                end
            end
        end
        drain();

        for (ph = 0; ph < 18; ph++)
        begin
            case (ph / 6)
                0: begin in_idle_pct = 29; out_idle_pct = 84; end
                1: begin in_idle_pct = 84; out_idle_pct = 29; end
                default: begin in_idle_pct = 0; out_idle_pct = 0; end
            endcase
            write_reg(tlbfl_pkg::REG_POLICY, 17'(pols[ph % 6]));
            write_reg(tlbfl_pkg::REG_LIMIT, 17'(limits[(ph + ph / 6) % 6]));
            write_reg(tlbfl_pkg::REG_PSIZE, sizes[(ph * 5) % 6]);
            for (int k = 0; k < 4; k++)
                pid_pool[k] = 16'($urandom);
            n = 72;
            for (int k = 0; k < n; k++)
                send(random_request());
            drain();
        end

        if (errors == 0)
            $display("tlb_translate_fifo_lru_unit: match");
        else
            $display("tlb_translate_fifo_lru_unit: mismatch");
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
hw/rtl/tlbfl_pkg.sv
hw/rtl/tlbfl_datapath.sv
hw/rtl/tlbfl_ctrl.sv
hw/rtl/tlb_translate_fifo_lru_unit.sv
verif/testbench.sv
